@@ hw/rtl/lrm_pkg.sv @@
// lrm_pkg: shared constants and types for the lcg random modulo block
// no dependencies; used by lrm_lcg, lrm_divider, lcg_random_modulo and lrm_checker
package lrm_pkg;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned DRAW_W  = 31;
  localparam int unsigned MOD_W   = 32;

  // the first step keeps bits 16..26, the next two keep bits 16..25
  localparam int unsigned FIRST_BITS = 11;
  localparam int unsigned NEXT_BITS  = 10;

  localparam int unsigned STEP_CNT_W = 2;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = 2'd2;

  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DRAW_W - 1);

  localparam logic [31:0] SEED_RESET = 32'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LCG  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } seq_state_t;

endpackage

@@ hw/rtl/lcg_random_modulo.sv @@
// lcg_random_modulo: top level, sequencer around the lcg step unit and remainder unit
// depends on lrm_pkg, lrm_lcg, lrm_divider
//
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  modulus
//  out      out        out_valid / out_stall value, zero_modulus
//  cfg      in         cfg_valid / cfg_ready cfg_data (start seed)
//
// a nonzero modulus passes from transfer to result through three lcg steps,
// 31 remainder iterations, the done pulse and the load of the output register
// a zero modulus skips the remainder unit and goes from the lcg steps to the load
// the remainder loop is bit-serial; in_stall stays high until the load
// rst is synchronous; it clears the generator state and seeded flag, start seed returns to 1
// a stalled result holds in the output register while the next request is taken
module lcg_random_modulo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lrm_pkg::MOD_W-1:0]    modulus,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrm_pkg::DRAW_W-1:0]   value,
  output logic                         zero_modulus,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrm_pkg::STATE_W-1:0]  cfg_data
);

  lrm_pkg::seq_state_t               state;
  lrm_pkg::seq_state_t               state_next;
  logic [lrm_pkg::STATE_W-1:0]       start_seed;
  logic                              seeded;
  logic [lrm_pkg::MOD_W-1:0]         mod_reg;
  logic [lrm_pkg::STEP_CNT_W-1:0]    step_cnt;
  logic [lrm_pkg::DRAW_W-1:0]        draw;
  logic [lrm_pkg::DRAW_W-1:0]        draw_next;
  logic [lrm_pkg::STATE_W-1:0]       lcg_next;
  logic [lrm_pkg::DRAW_W-1:0]        div_rem;
  lrm_pkg::div_status_t              div_status;
  logic                              in_xfer;
  logic                              lcg_load;
  logic                              lcg_step;
  logic                              div_start;
  logic                              last_step;
  logic                              out_load;
  logic                              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != lrm_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign lcg_load  = in_xfer && !seeded;
  assign lcg_step  = (state == lrm_pkg::ST_LCG);
  assign last_step = lcg_step && (step_cnt == lrm_pkg::LAST_STEP);
  assign div_start = last_step && (mod_reg != '0);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == lrm_pkg::ST_OUT) && out_free;

  lrm_lcg u_lcg (
    .clk        (clk),
    .rst        (rst),
    .load       (lcg_load),
    .seed       (start_seed),
    .step       (lcg_step),
    .state_next (lcg_next)
  );

  lrm_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (draw_next),
    .divisor   (mod_reg),
    .status    (div_status),
    .remainder (div_rem)
  );

  // first step takes 11 bits, later steps shift in 10 more
  always_comb begin
    if (step_cnt == '0) begin
      draw_next = {{(lrm_pkg::DRAW_W - lrm_pkg::FIRST_BITS){1'b0}},
                   lcg_next[16 +: lrm_pkg::FIRST_BITS]};
    end else begin
      draw_next = {draw[lrm_pkg::DRAW_W-lrm_pkg::NEXT_BITS-1:0],
                   lcg_next[16 +: lrm_pkg::NEXT_BITS]};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lrm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = lrm_pkg::ST_LCG;
        end
      end
      lrm_pkg::ST_LCG: begin
        if (last_step) begin
          state_next = (mod_reg != '0) ? lrm_pkg::ST_DIV : lrm_pkg::ST_OUT;
        end
      end
      lrm_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_next = lrm_pkg::ST_OUT;
        end
      end
      lrm_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = lrm_pkg::ST_IDLE;
        end
      end
      default: state_next = lrm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrm_pkg::ST_IDLE;
      seeded     <= 1'b0;
      start_seed <= lrm_pkg::SEED_RESET;
      step_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        start_seed <= cfg_data;
      end
      if (in_xfer) begin
        seeded   <= 1'b1;
        step_cnt <= '0;
      end else if (lcg_step) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mod_reg <= modulus;
    end
    if (lcg_step) begin
      draw <= draw_next;
    end
    if (out_load) begin
      zero_modulus <= (mod_reg == '0);
      value        <= (mod_reg == '0) ? '0 : div_rem;
    end
  end

endmodule

@@ hw/rtl/lrm_lcg.sv @@
// lrm_lcg: generator state register with one linear congruential step per cycle while step is high
// depends on lrm_pkg
module lrm_lcg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [lrm_pkg::STATE_W-1:0]  seed,
  input  logic                         step,
  output logic [lrm_pkg::STATE_W-1:0]  state_next
);

  logic [lrm_pkg::STATE_W-1:0] gen_state;
  logic [lrm_pkg::STATE_W-1:0] product;

  // only the low word of the product matters
  assign product    = gen_state * lrm_pkg::LCG_MUL;
  assign state_next = product + lrm_pkg::LCG_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
    end else if (load) begin
      gen_state <= seed;
    end else if (step) begin
      gen_state <= state_next;
    end
  end

endmodule

@@ hw/rtl/lrm_divider.sv @@
// lrm_divider: restoring bit-serial remainder unit, one quotient bit per cycle while busy
// depends on lrm_pkg
module lrm_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lrm_pkg::DRAW_W-1:0]   dividend,
  input  logic [lrm_pkg::MOD_W-1:0]    divisor,
  output lrm_pkg::div_status_t         status,
  output logic [lrm_pkg::DRAW_W-1:0]   remainder
);

  logic [lrm_pkg::DRAW_W-1:0]    num;
  logic [lrm_pkg::MOD_W-1:0]     rem;
  logic [lrm_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [lrm_pkg::MOD_W:0]       rem_shift;
  logic [lrm_pkg::MOD_W:0]       rem_diff;

  assign rem_shift = {rem, num[lrm_pkg::DRAW_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == lrm_pkg::DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (busy) begin
      num <= {num[lrm_pkg::DRAW_W-2:0], 1'b0};
      // rem stays below divisor, so the difference fits the low word
      if (!rem_diff[lrm_pkg::MOD_W]) begin
        rem <= rem_diff[lrm_pkg::MOD_W-1:0];
      end else begin
        rem <= rem_shift[lrm_pkg::MOD_W-1:0];
      end
    end
  end

  // remainder never exceeds the 31-bit dividend
  assign remainder   = rem[lrm_pkg::DRAW_W-1:0];
  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ hw/rtl/lrm_checker.sv @@
// lrm_checker: port-level checks for lcg_random_modulo, bound to the top level
// depends on lrm_pkg for field widths
module lrm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lrm_pkg::DRAW_W-1:0]   value,
  input logic                         zero_modulus
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(zero_modulus))
    else $error("result changed while stalled");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_modulus |-> value == '0)
    else $error("zero modulus result with nonzero value");

  // one request at a time: a transfer makes the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // no result can appear right after a request was taken
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after request");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind lcg_random_modulo lrm_checker u_lrm_checker (.*);
